// ----- hdl/vfc_pkg.sv -----
package vfc_pkg;

  localparam int SIZE_X  = 16;
  localparam int SIZE_Y  = 256;
  localparam int SIZE_Z  = 16;
  localparam int ID_BITS = 8;

  localparam int XY_SLICE    = SIZE_X * SIZE_Y;
  localparam int YZ_SLICE    = SIZE_Y * SIZE_Z;
  localparam int CHUNK_DEPTH = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int BND_DEPTH   = 2 * XY_SLICE + 2 * YZ_SLICE;
  localparam int CHUNK_AW    = $clog2(CHUNK_DEPTH);
  localparam int BND_AW      = $clog2(BND_DEPTH);

  localparam logic [1:0] OP_WRITE_CHUNK = 2'd0;
  localparam logic [1:0] OP_WRITE_BOUND = 2'd1;
  localparam logic [1:0] OP_QUERY       = 2'd2;

  localparam logic [2:0] SIDE_LAST = 3'd5;

  typedef struct packed {
    logic [1:0] opcode;
    logic [3:0] cell_x;
    logic [7:0] cell_y;
    logic [3:0] cell_z;
    logic [1:0] neighbor_sel;
    logic [7:0] block_value;
  } req_item_t;

  typedef struct packed {
    logic [2:0] face_side;
    logic [3:0] face_x;
    logic [7:0] face_y;
    logic [3:0] face_z;
    logic [7:0] face_block;
    logic       last_face;
  } face_item_t;

endpackage

// ----- hdl/vfc_channels.sv -----
interface vfc_req_if;
  logic                 valid;
  logic                 ready;
  vfc_pkg::req_item_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface vfc_face_if;
  logic                 valid;
  logic                 ready;
  vfc_pkg::face_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/vfc_ram.sv -----
module vfc_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/vfc_ctrl.sv -----
module vfc_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [3:0]                    cfg_wr_data,
  vfc_req_if.sink                       req,
  vfc_face_if.source                    rsp,
  output logic                          chunk_we,
  output logic [vfc_pkg::CHUNK_AW-1:0]  chunk_addr,
  output logic [vfc_pkg::ID_BITS-1:0]   chunk_wdata,
  input  logic [vfc_pkg::ID_BITS-1:0]   chunk_rdata,
  output logic                          bnd_we,
  output logic [vfc_pkg::BND_AW-1:0]    bnd_addr,
  output logic [vfc_pkg::ID_BITS-1:0]   bnd_wdata,
  input  logic [vfc_pkg::ID_BITS-1:0]   bnd_rdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_QUERY, ST_EMIT} state_t;
  typedef enum logic [1:0] {SRC_CHUNK, SRC_BOUND, SRC_OPEN} src_t;

  function automatic logic [vfc_pkg::CHUNK_AW-1:0] chunk_index(
    input logic [3:0] x, input logic [7:0] y, input logic [3:0] z);
    return vfc_pkg::CHUNK_AW'((int'(x) * vfc_pkg::SIZE_Y + int'(y)) * vfc_pkg::SIZE_Z
                              + int'(z));
  endfunction

  function automatic logic [vfc_pkg::BND_AW-1:0] slice_index(
    input logic [1:0] sel, input logic [3:0] x, input logic [7:0] y, input logic [3:0] z);
    if (sel < 2'd2) begin
      return vfc_pkg::BND_AW'(int'(sel) * vfc_pkg::XY_SLICE + int'(x) * vfc_pkg::SIZE_Y
                              + int'(y));
    end
    return vfc_pkg::BND_AW'(2 * vfc_pkg::XY_SLICE + int'(sel[0]) * vfc_pkg::YZ_SLICE
                            + int'(y) * vfc_pkg::SIZE_Z + int'(z));
  endfunction

  state_t                      state;
  logic [2:0]                  step;
  src_t                        src_prev;
  logic [5:0]                  mask;
  logic [vfc_pkg::ID_BITS-1:0] id;
  logic [3:0]                  x;
  logic [7:0]                  y;
  logic [3:0]                  z;
  logic [3:0]                  neighbor_present;

  logic       accept;
  logic       emit;
  logic       xyz_ok;
  logic       bnd_ok;
  src_t       src;
  logic [3:0] nx;
  logic [7:0] ny;
  logic [3:0] nz;
  logic [1:0] bsel;
  logic       cell_open;
  logic [5:0] low;
  logic [2:0] low_side;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign emit      = (state == ST_EMIT) && (mask != 6'd0) && (!rsp.valid || rsp.ready);

  assign xyz_ok = (int'(req.payload.cell_x) < vfc_pkg::SIZE_X)
               && (int'(req.payload.cell_y) < vfc_pkg::SIZE_Y)
               && (int'(req.payload.cell_z) < vfc_pkg::SIZE_Z);
  assign bnd_ok = (int'(req.payload.cell_y) < vfc_pkg::SIZE_Y)
               && ((req.payload.neighbor_sel < 2'd2)
                   ? (int'(req.payload.cell_x) < vfc_pkg::SIZE_X)
                   : (int'(req.payload.cell_z) < vfc_pkg::SIZE_Z));

  always_comb begin
    nx   = x;
    ny   = y;
    nz   = z;
    bsel = 2'd0;
    src  = SRC_CHUNK;
    case (step)
      3'd0: src = SRC_CHUNK;
      3'd1: begin
        if (z == 4'd0) begin
          bsel = 2'd0;
          src  = neighbor_present[0] ? SRC_BOUND : SRC_OPEN;
        end else begin
          nz = z - 4'd1;
        end
      end
      3'd2: begin
        if (int'(z) == vfc_pkg::SIZE_Z - 1) begin
          bsel = 2'd1;
          src  = neighbor_present[1] ? SRC_BOUND : SRC_OPEN;
        end else begin
          nz = z + 4'd1;
        end
      end
      3'd3: begin
        if (y == 8'd0) begin
          src = SRC_OPEN;
        end else begin
          ny = y - 8'd1;
        end
      end
      3'd4: begin
        if (int'(y) == vfc_pkg::SIZE_Y - 1) begin
          src = SRC_OPEN;
        end else begin
          ny = y + 8'd1;
        end
      end
      3'd5: begin
        if (x == 4'd0) begin
          bsel = 2'd2;
          src  = neighbor_present[2] ? SRC_BOUND : SRC_OPEN;
        end else begin
          nx = x - 4'd1;
        end
      end
      3'd6: begin
        if (int'(x) == vfc_pkg::SIZE_X - 1) begin
          bsel = 2'd3;
          src  = neighbor_present[3] ? SRC_BOUND : SRC_OPEN;
        end else begin
          nx = x + 4'd1;
        end
      end
      default: src = SRC_OPEN;
    endcase
  end

  always_comb begin
    chunk_wdata = vfc_pkg::ID_BITS'(req.payload.block_value);
    bnd_wdata   = vfc_pkg::ID_BITS'(req.payload.block_value);
    if (state == ST_IDLE) begin
      chunk_we   = accept && (req.payload.opcode == vfc_pkg::OP_WRITE_CHUNK) && xyz_ok;
      bnd_we     = accept && (req.payload.opcode == vfc_pkg::OP_WRITE_BOUND) && bnd_ok;
      chunk_addr = chunk_index(req.payload.cell_x, req.payload.cell_y, req.payload.cell_z);
      bnd_addr   = slice_index(req.payload.neighbor_sel, req.payload.cell_x,
                               req.payload.cell_y, req.payload.cell_z);
    end else begin
      chunk_we   = 1'b0;
      bnd_we     = 1'b0;
      chunk_addr = chunk_index(nx, ny, nz);
      bnd_addr   = slice_index(bsel, x, y, z);
    end
  end

  always_comb begin
    case (src_prev)
      SRC_CHUNK: cell_open = (chunk_rdata == '0);
      SRC_BOUND: cell_open = (bnd_rdata == '0);
      default:   cell_open = 1'b1;
    endcase
  end

  always_comb begin
    low      = mask & (~mask + 6'd1);
    low_side = 3'd0;
    for (int i = 0; i < 6; i++) begin
      if (low[i]) begin
        low_side = 3'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      step             <= 3'd0;
      src_prev         <= SRC_OPEN;
      neighbor_present <= 4'd0;
      rsp.valid        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        neighbor_present <= cfg_wr_data;
      end
      if (rsp.ready && !emit) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            x <= req.payload.cell_x;
            y <= req.payload.cell_y;
            z <= req.payload.cell_z;
            if (req.payload.opcode == vfc_pkg::OP_QUERY && xyz_ok) begin
              state <= ST_QUERY;
              step  <= 3'd0;
            end
          end
        end
        ST_QUERY: begin
          src_prev <= src;
          step     <= step + 3'd1;
          if (step == 3'd1) begin
            id <= chunk_rdata;
            if (chunk_rdata == '0) begin
              state <= ST_IDLE;
            end
          end else if (step != 3'd0) begin
            mask[3'(step - 3'd2)] <= cell_open;
          end
          if (step == 3'd7) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (mask == 6'd0) begin
            state <= ST_IDLE;
          end else if (emit) begin
            rsp.valid                <= 1'b1;
            rsp.payload.face_side    <= low_side;
            rsp.payload.face_x       <= x;
            rsp.payload.face_y       <= y;
            rsp.payload.face_z       <= z;
            rsp.payload.face_block   <= 8'(id);
            rsp.payload.last_face    <= ((mask & ~low) == 6'd0);
            mask                     <= mask & ~low;
            if ((mask & ~low) == 6'd0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/voxel_face_culling.sv -----
// A write leaves the block idle, so the next item is accepted in the following cycle.
// A query walks the voxel and its six neighbors through single-port chunk and
// boundary memories, one read per cycle; faces then leave one per cycle while
// the face output is not stalled. A query holds off new items until its last face
// is placed on the output; an air voxel ends it early, and with no face exposed none is sent.
// Reset clears control state and neighbor_present; the memories are not cleared.
module voxel_face_culling (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,
  vfc_req_if.sink     req,
  vfc_face_if.source  rsp
);

  logic                         chunk_we;
  logic [vfc_pkg::CHUNK_AW-1:0] chunk_addr;
  logic [vfc_pkg::ID_BITS-1:0]  chunk_wdata;
  logic [vfc_pkg::ID_BITS-1:0]  chunk_rdata;
  logic                         bnd_we;
  logic [vfc_pkg::BND_AW-1:0]   bnd_addr;
  logic [vfc_pkg::ID_BITS-1:0]  bnd_wdata;
  logic [vfc_pkg::ID_BITS-1:0]  bnd_rdata;

  vfc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .rsp         (rsp),
    .chunk_we    (chunk_we),
    .chunk_addr  (chunk_addr),
    .chunk_wdata (chunk_wdata),
    .chunk_rdata (chunk_rdata),
    .bnd_we      (bnd_we),
    .bnd_addr    (bnd_addr),
    .bnd_wdata   (bnd_wdata),
    .bnd_rdata   (bnd_rdata)
  );

  vfc_ram #(
    .DEPTH (vfc_pkg::CHUNK_DEPTH),
    .WIDTH (vfc_pkg::ID_BITS)
  ) u_chunk_ram (
    .clk   (clk),
    .we    (chunk_we),
    .addr  (chunk_addr),
    .wdata (chunk_wdata),
    .rdata (chunk_rdata)
  );

  vfc_ram #(
    .DEPTH (vfc_pkg::BND_DEPTH),
    .WIDTH (vfc_pkg::ID_BITS)
  ) u_bnd_ram (
    .clk   (clk),
    .we    (bnd_we),
    .addr  (bnd_addr),
    .wdata (bnd_wdata),
    .rdata (bnd_rdata)
  );

  a_chunk_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    chunk_we |-> (req.valid && req.ready
                  && req.payload.opcode == vfc_pkg::OP_WRITE_CHUNK))
    else $error("chunk write without accepted write item");

  a_bnd_write_on_accept: assert property (@(posedge clk) disable iff (rst)
    bnd_we |-> (req.valid && req.ready
                && req.payload.opcode == vfc_pkg::OP_WRITE_BOUND))
    else $error("boundary write without accepted write item");

  a_no_air_face: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.payload.face_block != 8'd0))
    else $error("face emitted for air voxel");

  a_side_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.payload.face_side <= vfc_pkg::SIDE_LAST))
    else $error("face side out of range");

endmodule
